/* design/utf8d_pkg.sv */
package utf8d_pkg;

   // One source byte and the code point width.
   typedef logic [7:0]  byte_type;
   typedef logic [20:0] codepoint_type;
   typedef logic [15:0] limit_type;

   // Upper bounds of the byte classes.
   localparam byte_type ASCII_MAX = 8'h7F;
   localparam byte_type CONT_MAX  = 8'hBF;
   localparam byte_type LEAD2_MAX = 8'hDF;
   localparam byte_type LEAD3_MAX = 8'hEF;

   // Payload masks for continuation and lead bytes.
   localparam byte_type CONT_MASK  = 8'h3F;
   localparam byte_type LEAD2_MASK = 8'h1F;
   localparam byte_type LEAD3_MASK = 8'h0F;
   localparam byte_type LEAD4_MASK = 8'h07;

   localparam limit_type LIMIT_RESET = 16'hFFFF;

endpackage

/* design/utf8_byte_stream_decoder_core.sv */
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_in_byte[7:0]
// rsp       out        rsp_valid/rsp_ready    rsp_codepoint[20:0], rsp_cut
// csr       in         csr_wr_en (no wait)    csr_wr_data[15:0] (byte_limit)
//
// One byte is taken per cycle while the output is not stalled. A byte is held
// in the input register and its result, if any, is registered in the output
// register when the byte is decoded. The decode state (accumulator, pending
// count, byte budget) is updated in that same decode step.
// Reset is synchronous and active high; it clears all control state and
// loads the byte limit and the budget with 65535. A stalled result holds the
// input register, and a new byte is still taken in the cycle the result leaves.
module utf8_byte_stream_decoder_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  utf8d_pkg::byte_type     req_in_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output utf8d_pkg::codepoint_type rsp_codepoint,
   output logic                    rsp_cut,
   input  logic                    csr_wr_en,
   input  utf8d_pkg::limit_type    csr_wr_data
);
   import utf8d_pkg::*;

   // Input register: holds one accepted byte until it can be decoded.
   logic          s1_valid_ff, s1_valid_in;
   byte_type      s1_byte_ff,  s1_byte_in;

   // Decode state.
   codepoint_type acc_ff,        acc_in;
   logic [1:0]    pending_ff,    pending_in;
   limit_type     bytes_left_ff, bytes_left_in;
   logic          stopped_ff,    stopped_in;
   limit_type     byte_limit_ff, byte_limit_in;

   // Output register.
   logic          rsp_valid_ff,  rsp_valid_in;
   codepoint_type rsp_cp_ff,     rsp_cp_in;
   logic          rsp_cut_ff,    rsp_cut_in;

   logic          s1_advance;
   logic          emit;
   codepoint_type emit_cp;
   logic          emit_cut;

   // The byte in the input register is decoded when the output register is
   // free or is being drained in this cycle.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_in_byte;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Decode step for the byte in the input register.
   always_comb begin
      acc_in        = acc_ff;
      pending_in    = pending_ff;
      bytes_left_in = bytes_left_ff;
      stopped_in    = stopped_ff;
      byte_limit_in = byte_limit_ff;
      emit          = 1'b0;
      emit_cp       = '0;
      emit_cut      = 1'b0;

      if (s1_advance) begin
         priority if (s1_byte_ff == '0) begin
            // End of string: start over with a fresh budget.
            acc_in        = '0;
            pending_in    = '0;
            bytes_left_in = byte_limit_ff;
            stopped_in    = 1'b0;
         end else if (stopped_ff) begin
            // Bytes after the cut are dropped until the string ends.
         end else if (bytes_left_ff == '0) begin
            // Budget spent: one terminator flagged as cut, then stop.
            stopped_in = 1'b1;
            emit       = 1'b1;
            emit_cut   = 1'b1;
         end else begin
            bytes_left_in = bytes_left_ff - 16'd1;
            priority if (s1_byte_ff <= ASCII_MAX) begin
               acc_in     = {13'd0, s1_byte_ff};
               pending_in = 2'd0;
            end else if (s1_byte_ff <= CONT_MAX) begin
               // A stray continuation leaves the accumulator as it is.
               if (pending_ff != 2'd0) begin
                  acc_in     = {acc_ff[14:0], s1_byte_ff[5:0] & CONT_MASK[5:0]};
                  pending_in = pending_ff - 2'd1;
               end
            end else if (s1_byte_ff <= LEAD2_MAX) begin
               acc_in     = {13'd0, s1_byte_ff & LEAD2_MASK};
               pending_in = 2'd1;
            end else if (s1_byte_ff <= LEAD3_MAX) begin
               acc_in     = {13'd0, s1_byte_ff & LEAD3_MASK};
               pending_in = 2'd2;
            end else begin
               acc_in     = {13'd0, s1_byte_ff & LEAD4_MASK};
               pending_in = 2'd3;
            end
            // A finished sequence is sent and the accumulator cleared.
            if (pending_in == 2'd0) begin
               emit    = 1'b1;
               emit_cp = acc_in;
               acc_in  = '0;
            end
         end
      end

      // The user is to write the limit only while the block is idle; the block
      // does not enforce this. The budget follows the new value at once.
      if (csr_wr_en) begin
         byte_limit_in = csr_wr_data;
         bytes_left_in = csr_wr_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_cp_in    = rsp_cp_ff;
      rsp_cut_in   = rsp_cut_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_cp_in    = emit_cp;
         rsp_cut_in   = emit_cut;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         acc_ff        <= '0;
         pending_ff    <= '0;
         bytes_left_ff <= LIMIT_RESET;
         stopped_ff    <= 1'b0;
         byte_limit_ff <= LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         acc_ff        <= acc_in;
         pending_ff    <= pending_in;
         bytes_left_ff <= bytes_left_in;
         stopped_ff    <= stopped_in;
         byte_limit_ff <= byte_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      rsp_cp_ff  <= rsp_cp_in;
      rsp_cut_ff <= rsp_cut_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_codepoint = rsp_cp_ff;
   assign rsp_cut       = rsp_cut_ff;

`ifndef SYNTHESIS
   // A cut terminator always carries code point zero.
   a_cut_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cut_ff) |-> (rsp_cp_ff == '0))
      else $error("cut result with nonzero code point");

   // Stopping always goes together with loading the cut terminator.
   a_stop_emits_cut: assert property (@(posedge clock) disable iff (reset)
      $rose(stopped_ff) |-> (rsp_valid_ff && rsp_cut_ff))
      else $error("decoder stopped without a cut terminator");

   // A byte waiting on a full output register is kept.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_byte_ff)))
      else $error("waiting byte lost from input register");
`endif

endmodule
